### hdl/kwl_pkg.sv
// kwl_pkg: shared types, token codes and keyword tables of the keyword token lexer
// no dependencies; used by the interfaces, kwl_scan, kwl_id_store and the top level

package kwl_pkg;

  // token kinds
  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_VOID   = 4'd1;
  localparam logic [3:0] KIND_RETURN = 4'd2;
  localparam logic [3:0] KIND_ASSIGN = 4'd3;
  localparam logic [3:0] KIND_LPAREN = 4'd4;
  localparam logic [3:0] KIND_RPAREN = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_SEMI   = 4'd8;
  localparam logic [3:0] KIND_LIT    = 4'd9;
  localparam logic [3:0] KIND_IDENT  = 4'd10;
  localparam logic [3:0] KIND_ERROR  = 4'd11;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_LIT_OVF  = 2'd2;
  localparam logic [1:0] ERR_ID_LONG  = 2'd3;

  // keyword indexes
  localparam logic [1:0] KW_INT    = 2'd0;
  localparam logic [1:0] KW_VOID   = 2'd1;
  localparam logic [1:0] KW_RETURN = 2'd2;

  localparam logic [30:0] LIT_MAX = 31'h7fff_ffff;

  // one result item
  typedef struct packed {
    logic [3:0]  kind;
    logic [30:0] value;
    logic [7:0]  ch;
    logic        last;
    logic [1:0]  err;
    logic        send;
  } kwl_res_t;

  // identifier character stream from the store to the scanner
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] ch;
  } kwl_fl_t;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      KW_VOID:   n = 4'd3;
      KW_RETURN: n = 4'd9;
      default:   n = 4'd6;
    endcase
    return n;
  endfunction

  // keyword spelling, one byte per position
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] n);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      KW_VOID: begin
        case (n)
          4'd0:    c = "t";
          4'd1:    c = "o";
          4'd2:    c = "m";
          default: c = 8'h00;
        endcase
      end
      KW_RETURN: begin
        case (n)
          4'd0:    c = "r";
          4'd1:    c = "e";
          4'd2:    c = "t";
          4'd3:    c = "u";
          4'd4:    c = "r";
          4'd5:    c = "n";
          4'd6:    c = "e";
          4'd7:    c = "r";
          4'd8:    c = "a";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (n)
          4'd0:    c = "h";
          4'd1:    c = "e";
          4'd2:    c = "l";
          4'd3:    c = "t";
          4'd4:    c = "a";
          4'd5:    c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

### hdl/kwl_if.sv
// kwl_if: valid/ready channel interfaces for source bytes and result items
// depends on kwl_pkg

interface kwl_in_if;
  import kwl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       source_end;

  modport source (output valid, output source_char, output source_end, input ready);
  modport sink (input valid, input source_char, input source_end, output ready);
endinterface

interface kwl_out_if;
  import kwl_pkg::*;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [30:0] literal_value;
  logic [7:0]  text_char;
  logic        text_last;
  logic [1:0]  error_code;
  logic        stream_end;

  modport source (output valid, output token_kind, output literal_value, output text_char,
                  output text_last, output error_code, output stream_end, input ready);
  modport sink (input valid, input token_kind, input literal_value, input text_char,
                input text_last, input error_code, input stream_end, output ready);
endinterface

### hdl/kwl_id_store.sv
// kwl_id_store: identifier character memory with a streaming read-out sequencer
// depends on kwl_pkg

module kwl_id_store #(
  parameter int MAX_ID_LEN = 32,
  localparam int AW = $clog2(MAX_ID_LEN),
  localparam int LW = $clog2(MAX_ID_LEN + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic            fl_start,
  input  logic [LW-1:0]   fl_len,
  input  logic            fl_take,
  output kwl_pkg::kwl_fl_t fl
);
  import kwl_pkg::*;

  logic [7:0]    mem [MAX_ID_LEN];
  logic [7:0]    rdata_r;
  logic [LW-1:0] rd_idx_r, rd_idx_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          have_r, have_nxt;
  logic          busy_r, busy_nxt;
  logic          rd_en;

  // read ahead as long as the data register is free or being drained
  assign rd_en = busy_r && (rd_idx_r != len_r) && (!have_r || fl_take);

  assign fl.valid = have_r;
  assign fl.last  = (rd_idx_r == len_r);
  assign fl.ch    = rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    len_nxt    = len_r;
    have_nxt   = have_r;
    busy_nxt   = busy_r;
    if (fl_start) begin
      rd_idx_nxt = '0;
      len_nxt    = fl_len;
      have_nxt   = 1'b0;
      busy_nxt   = 1'b1;
    end else begin
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        have_nxt   = 1'b1;
      end else if (fl_take) begin
        have_nxt = 1'b0;
      end
      if (fl_take && fl.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      len_r    <= '0;
      have_r   <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      len_r    <= len_nxt;
      have_r   <= have_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // no write may land while a read-out is in flight
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !busy_r)
    else $error("identifier write during read-out");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rd_idx_r <= len_r))
    else $error("read index past identifier length");
  a_have_read: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (rd_idx_r != '0))
    else $error("data held without a read issued");

endmodule

### hdl/kwl_scan.sv
// kwl_scan: byte sequencer of the lexer, keyword/literal/identifier scanning
// depends on kwl_pkg; drives kwl_id_store through its write and read-out ports

module kwl_scan #(
  parameter int MAX_ID_LEN = 32,
  localparam int AW = $clog2(MAX_ID_LEN),
  localparam int LW = $clog2(MAX_ID_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_char,
  input  logic              in_end,
  output logic              in_ready,
  input  logic              res_ready,
  output logic              res_valid,
  output kwl_pkg::kwl_res_t res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              fl_start,
  output logic [LW-1:0]     fl_len,
  output logic              fl_take,
  input  kwl_pkg::kwl_fl_t  fl
);
  import kwl_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_PASS  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_ENDF  = 2'd3;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_KEYWORD = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_IDENT   = 3'd3;
  localparam logic [2:0] MODE_SKIP    = 3'd4;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  logic [1:0]    st_r, st_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [1:0]    kcand_r, kcand_nxt;
  logic [3:0]    kcnt_r, kcnt_nxt;
  logic [30:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] idlen_r, idlen_nxt;
  logic [7:0]    c_r, c_nxt;
  logic          end_r, end_nxt;
  logic          fend_r, fend_nxt;

  logic [7:0]    cur_c;
  logic          cur_end;
  logic          go;
  logic          p_rehandle;
  logic          p_flush;
  logic [34:0]   acc_x10;

  assign cur_c    = (st_r == ST_RUN) ? in_char : c_r;
  assign cur_end  = (st_r == ST_RUN) ? in_end : end_r;
  assign in_ready = (st_r == ST_RUN) && res_ready;
  assign go       = (st_r == ST_RUN) ? (in_valid && res_ready) : ((st_r == ST_PASS) && res_ready);
  assign fl_len   = idlen_r;

  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {31'b0, cur_c[3:0]};

  always_comb begin
    st_nxt     = st_r;
    mode_nxt   = mode_r;
    kcand_nxt  = kcand_r;
    kcnt_nxt   = kcnt_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    idlen_nxt  = idlen_r;
    c_nxt      = c_r;
    end_nxt    = end_r;
    fend_nxt   = fend_r;
    res_valid  = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = idlen_r[AW-1:0];
    wr_data    = cur_c;
    fl_start   = 1'b0;
    fl_take    = 1'b0;
    p_rehandle = 1'b0;
    p_flush    = 1'b0;

    case (st_r)
      ST_RUN, ST_PASS: begin
        if (go) begin
          if (st_r == ST_RUN) begin
            c_nxt   = in_char;
            end_nxt = in_end;
          end
          case (mode_r)
            MODE_SKIP: begin
            end
            MODE_NUMBER: begin
              if (is_digit(cur_c)) begin
                if (!ovf_r) begin
                  if (acc_x10 > {4'b0, LIT_MAX}) begin
                    ovf_nxt = 1'b1;
                    acc_nxt = LIT_MAX;
                  end else begin
                    acc_nxt = acc_x10[30:0];
                  end
                end
              end else if (ovf_r) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.err   = ERR_LIT_OVF;
                res.send  = cur_end;
                mode_nxt  = MODE_SKIP;
                acc_nxt   = '0;
                ovf_nxt   = 1'b0;
              end else begin
                // literal ends; the byte is handled again from idle
                res_valid  = 1'b1;
                res.kind   = KIND_LIT;
                res.value  = acc_r;
                res.send   = cur_end && is_space(cur_c);
                mode_nxt   = MODE_IDLE;
                acc_nxt    = '0;
                p_rehandle = 1'b1;
              end
            end
            MODE_IDENT: begin
              if (is_alpha(cur_c) || is_digit(cur_c) || (cur_c == "_")) begin
                if (idlen_r >= LW'(MAX_ID_LEN)) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  res.err   = ERR_ID_LONG;
                  res.send  = cur_end;
                  idlen_nxt = '0;
                  mode_nxt  = MODE_SKIP;
                end else begin
                  wr_en     = 1'b1;
                  idlen_nxt = idlen_r + 1'b1;
                end
              end else begin
                p_flush = 1'b1;
              end
            end
            MODE_KEYWORD: begin
              if ((kcnt_r < kw_len(kcand_r)) && (kw_char(kcand_r, kcnt_r) == cur_c)) begin
                // prefix keeps growing; the buffer holds it in case it breaks
                wr_en     = 1'b1;
                kcnt_nxt  = kcnt_r + 1'b1;
                idlen_nxt = idlen_r + 1'b1;
                if ((kcnt_r + 1'b1) == kw_len(kcand_r)) begin
                  res_valid = 1'b1;
                  res.kind  = {2'b0, kcand_r};
                  res.send  = cur_end;
                  idlen_nxt = '0;
                  kcnt_nxt  = '0;
                  mode_nxt  = MODE_IDLE;
                end
              end else begin
                kcnt_nxt   = '0;
                mode_nxt   = MODE_IDENT;
                p_rehandle = 1'b1;
              end
            end
            default: begin
              mode_nxt = MODE_IDLE;
              res.send = cur_end;
              case (cur_c)
                "=": begin res_valid = 1'b1; res.kind = KIND_ASSIGN; end
                "(": begin res_valid = 1'b1; res.kind = KIND_LPAREN; end
                ")": begin res_valid = 1'b1; res.kind = KIND_RPAREN; end
                "{": begin res_valid = 1'b1; res.kind = KIND_LBRACE; end
                "}": begin res_valid = 1'b1; res.kind = KIND_RBRACE; end
                ";": begin res_valid = 1'b1; res.kind = KIND_SEMI; end
                default: begin
                  if (is_space(cur_c)) begin
                  end else if (is_digit(cur_c)) begin
                    acc_nxt  = {27'b0, cur_c[3:0]};
                    ovf_nxt  = 1'b0;
                    mode_nxt = MODE_NUMBER;
                  end else if (is_alpha(cur_c) || (cur_c == "_")) begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    idlen_nxt = LW'(1);
                    mode_nxt  = MODE_IDENT;
                    if (cur_c == kw_char(KW_INT, 4'd0)) begin
                      kcand_nxt = KW_INT;
                      kcnt_nxt  = 4'd1;
                      mode_nxt  = MODE_KEYWORD;
                    end else if (cur_c == kw_char(KW_VOID, 4'd0)) begin
                      kcand_nxt = KW_VOID;
                      kcnt_nxt  = 4'd1;
                      mode_nxt  = MODE_KEYWORD;
                    end else if (cur_c == kw_char(KW_RETURN, 4'd0)) begin
                      kcand_nxt = KW_RETURN;
                      kcnt_nxt  = 4'd1;
                      mode_nxt  = MODE_KEYWORD;
                    end
                  end else begin
                    res_valid = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.err   = ERR_BAD_CHAR;
                    mode_nxt  = MODE_SKIP;
                  end
                end
              endcase
            end
          endcase

          if (p_flush) begin
            st_nxt   = ST_FLUSH;
            fl_start = 1'b1;
            fend_nxt = 1'b0;
          end else if (p_rehandle) begin
            st_nxt = ST_PASS;
          end else if (cur_end) begin
            st_nxt = ST_ENDF;
          end else begin
            st_nxt = ST_RUN;
          end
        end
      end

      ST_FLUSH: begin
        res_valid = fl.valid && res_ready;
        res.kind  = KIND_IDENT;
        res.ch    = fl.ch;
        res.last  = fl.last;
        res.send  = fl.last && (fend_r || (end_r && is_space(c_r)));
        fl_take   = fl.valid && res_ready;
        if (fl_take && fl.last) begin
          idlen_nxt = '0;
          kcnt_nxt  = '0;
          mode_nxt  = MODE_IDLE;
          if (fend_r) begin
            kcand_nxt = '0;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
            st_nxt    = ST_RUN;
          end else begin
            st_nxt = ST_PASS;
          end
        end
      end

      ST_ENDF: begin
        if (res_ready) begin
          if ((mode_r == MODE_IDENT) || (mode_r == MODE_KEYWORD)) begin
            st_nxt   = ST_FLUSH;
            fl_start = 1'b1;
            fend_nxt = 1'b1;
          end else begin
            if (mode_r == MODE_NUMBER) begin
              res_valid = 1'b1;
              res.send  = 1'b1;
              if (ovf_r) begin
                res.kind = KIND_ERROR;
                res.err  = ERR_LIT_OVF;
              end else begin
                res.kind  = KIND_LIT;
                res.value = acc_r;
              end
            end
            mode_nxt  = MODE_IDLE;
            kcand_nxt = '0;
            kcnt_nxt  = '0;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
            idlen_nxt = '0;
            st_nxt    = ST_RUN;
          end
        end
      end

      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RUN;
      mode_r  <= MODE_IDLE;
      kcand_r <= '0;
      kcnt_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      idlen_r <= '0;
      end_r   <= 1'b0;
      fend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      kcand_r <= kcand_nxt;
      kcnt_r  <= kcnt_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      idlen_r <= idlen_nxt;
      end_r   <= end_nxt;
      fend_r  <= fend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
  end

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> res_ready)
    else $error("result issued with no free output slot");
  a_flush_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH) |-> ((mode_r == MODE_IDENT) || (mode_r == MODE_KEYWORD)))
    else $error("read-out outside an identifier");
  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_KEYWORD) |-> ((kcnt_r != 4'd0) && (idlen_r == LW'(kcnt_r))))
    else $error("keyword prefix and buffer length disagree");

endmodule

### hdl/keyword_token_lexer_unit.sv
// keyword_token_lexer_unit: top level of the keyword token lexer
// a broken keyword prefix, or an ended literal that did not overflow, has its ending byte
// handled a second time; an ended identifier is read out first and then its ending byte is
// handled again; the end byte is followed by an end check
// an identifier is read out of the identifier memory through a registered read, one memory
// read per cycle while the output register can take the characters
// results leave through one output register, in the cycle after they are formed
// rst_n is synchronous, active low: scanner, read-out and output register go idle; the
// identifier memory is not cleared, as an entry is always written before it is read
// depends on kwl_pkg, kwl_if, kwl_id_store and kwl_scan

module keyword_token_lexer_unit #(
  parameter int MAX_ID_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kwl_in_if.sink    in_ch,
  kwl_out_if.source out_ch
);
  import kwl_pkg::*;

  localparam int AW = $clog2(MAX_ID_LEN);
  localparam int LW = $clog2(MAX_ID_LEN + 1);

  // scanner to output register
  logic          res_ready;
  logic          res_valid;
  kwl_res_t      res;

  // scanner to identifier memory
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          fl_start;
  logic [LW-1:0] fl_len;
  logic          fl_take;
  kwl_fl_t       fl;

  // output register
  logic          out_valid_r, out_valid_nxt;
  kwl_res_t      out_res_r, out_res_nxt;

  // the register is free when empty or when its item leaves this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  kwl_scan #(
    .MAX_ID_LEN(MAX_ID_LEN)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_char  (in_ch.source_char),
    .in_end   (in_ch.source_end),
    .in_ready (in_ch.ready),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .fl_start (fl_start),
    .fl_len   (fl_len),
    .fl_take  (fl_take),
    .fl       (fl)
  );

  // identifier characters live here until the token ends
  kwl_id_store #(
    .MAX_ID_LEN(MAX_ID_LEN)
  ) u_id_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .fl_start(fl_start),
    .fl_len  (fl_len),
    .fl_take (fl_take),
    .fl      (fl)
  );

  // output register load and drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.token_kind    = out_res_r.kind;
  assign out_ch.literal_value = out_res_r.value;
  assign out_ch.text_char     = out_res_r.ch;
  assign out_ch.text_last     = out_res_r.last;
  assign out_ch.error_code    = out_res_r.err;
  assign out_ch.stream_end    = out_res_r.send;

endmodule

### sim/testbench.sv
// testbench: self-checking bench for keyword_token_lexer_unit, driving source bytes and checking
// every token item against hand-written tokens or a behavioral lexer kept in step with the stimulus
// depends on kwl_pkg, kwl_if (kwl_in_if, kwl_out_if) and the keyword_token_lexer_unit rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kwl_pkg::*;

  localparam int NAME_MAX      = 32;    // longest identifier the block keeps
  localparam int RAND_ITEMS    = 105;   // source bytes in the random part
  localparam int CALM_ITEMS    = 25;    // closing stretch with no idling on either side
  localparam int PHRASE_KINDS  = 10;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES   = 40;

  // one token item as it leaves the block
  typedef struct packed {
    logic [3:0]  kind;
    logic [30:0] value;
    logic [7:0]  ch;
    logic        last;
    logic [1:0]  err;
    logic        stream_end;
  } token_t;

  // one row of the directed byte table; tok only holds when typed is set
  typedef struct {
    logic [7:0] c;
    logic       e;
    bit         typed;
    token_t     tok;
  } dir_row_t;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_KEYWORD, SCAN_NUMBER, SCAN_IDENT, SCAN_SKIP
  } scan_mode_e;

  // shapes of random source text
  typedef enum int {
    PH_KEYWORD, PH_BROKEN_KW, PH_MARK, PH_LITERAL, PH_LIT_EDGE,
    PH_NAME, PH_LONG_NAME, PH_BAD_BYTE, PH_SPACE, PH_NOISE
  } phrase_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  kwl_in_if  in_if ();
  kwl_out_if out_if ();

  keyword_token_lexer_unit #(
    .MAX_ID_LEN(NAME_MAX)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #4 clk = ~clk;

  // keyword spellings and the token kind each one yields
  string      kw_word [3] = '{"heltal", "tom", "returnera"};
  logic [3:0] kw_kind [3] = '{KIND_INT, KIND_VOID, KIND_RETURN};
  string      marks       = "=(){};";
  string      bad_ascii   = "!#$%&*+,-./:<>?@[]^`|~";

  // ---------------------------------------------------------------------------
  // behavioral lexer: its own copy of the scan state
  // ---------------------------------------------------------------------------
  scan_mode_e  lx_mode;
  logic [1:0]  lx_kw;        // keyword being matched
  int          lx_kw_cnt;    // characters of it matched so far
  logic [30:0] lx_acc;       // literal value, saturated
  logic        lx_ovf;
  logic [7:0]  lx_name [NAME_MAX];
  int          lx_name_len;

  token_t byte_tokens[$];     // tokens caused by the byte just handled
  token_t pending_tokens[$];  // tokens still owed by the block, oldest first
  logic [7:0] phrase_q[$];    // next run of random source bytes

  int  mismatch_count;
  bit  tx_calm;
  bit  rx_calm;
  int  rx_hold_req;
  dir_row_t dir_rows[$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
  endfunction

  function automatic void put_token(logic [3:0] kind, logic [30:0] value, logic [7:0] ch,
                                    logic last, logic [1:0] err);
    token_t t;
    t.kind       = kind;
    t.value      = value;
    t.ch         = ch;
    t.last       = last;
    t.err        = err;
    t.stream_end = 1'b0;
    byte_tokens = {byte_tokens, t};
  endfunction

  // an error token, then everything is skipped until the source end
  function automatic void lex_error(logic [1:0] code);
    put_token(KIND_ERROR, '0, 8'h00, 1'b1, code);
    lx_mode = SCAN_SKIP;
  endfunction

  function automatic void flush_name();
    for (int i = 0; i < lx_name_len && i < NAME_MAX; i++)
      put_token(KIND_IDENT, '0, lx_name[i], (i + 1 == lx_name_len), ERR_NONE);
    lx_name_len = 0;
    lx_mode = SCAN_IDLE;
  endfunction

  function automatic void flush_number();
    if (lx_ovf) begin
      lex_error(ERR_LIT_OVF);
    end else begin
      put_token(KIND_LIT, lx_acc, 8'h00, 1'b1, ERR_NONE);
      lx_mode = SCAN_IDLE;
    end
    lx_acc = '0;
    lx_ovf = 1'b0;
  endfunction

  function automatic void lex_reset();
    lx_mode     = SCAN_IDLE;
    lx_kw       = KW_INT;
    lx_kw_cnt   = 0;
    lx_acc      = '0;
    lx_ovf      = 1'b0;
    lx_name_len = 0;
  endfunction

  // a byte seen between tokens
  function automatic void open_token(logic [7:0] c);
    logic [3:0] mk;
    bit         is_mark;
    string      w;
    is_mark = 1'b1;
    mk = KIND_ASSIGN;
    case (c)
      "=":     mk = KIND_ASSIGN;
      "(":     mk = KIND_LPAREN;
      ")":     mk = KIND_RPAREN;
      "{":     mk = KIND_LBRACE;
      "}":     mk = KIND_RBRACE;
      ";":     mk = KIND_SEMI;
      default: is_mark = 1'b0;
    endcase
    if (is_mark) begin
      put_token(mk, '0, 8'h00, 1'b1, ERR_NONE);
    end else if (is_digit(c)) begin
      lx_acc  = 31'(c - "0");
      lx_ovf  = 1'b0;
      lx_mode = SCAN_NUMBER;
    end else if (is_word(c)) begin
      // a word start may be the first letter of a keyword
      lx_name[0]  = c;
      lx_name_len = 1;
      lx_mode     = SCAN_IDENT;
      for (int k = 0; k < 3; k++) begin
        w = kw_word[k];
        if (w[0] == c) begin
          lx_kw     = 2'(k);
          lx_kw_cnt = 1;
          lx_mode   = SCAN_KEYWORD;
        end
      end
    end else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
      lex_error(ERR_BAD_CHAR);
    end
  endfunction

  // handles one byte in the current mode; 1 means the byte must be looked at again
  function automatic bit lex_byte(logic [7:0] c);
    longint unsigned t;
    string w;
    int    n;
    case (lx_mode)
      SCAN_SKIP: return 1'b0;
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          if (!lx_ovf) begin
            t = lx_acc;
            t = t * 10 + c - "0";
            if (t > LIT_MAX) begin
              lx_ovf = 1'b1;
              t = LIT_MAX;
            end
            lx_acc = t[30:0];
          end
          return 1'b0;
        end
        // the ending byte is dropped when the literal overflowed
        flush_number();
        return lx_mode != SCAN_SKIP;
      end
      SCAN_IDENT: begin
        if (is_word(c)) begin
          if (lx_name_len >= NAME_MAX) begin
            lx_name_len = 0;
            lex_error(ERR_ID_LONG);
          end else begin
            lx_name[lx_name_len] = c;
            lx_name_len++;
          end
          return 1'b0;
        end
        flush_name();
        return 1'b1;
      end
      SCAN_KEYWORD: begin
        w = kw_word[lx_kw];
        n = lx_kw_cnt;
        if (n < w.len() && w[n] == c) begin
          lx_name[n]  = c;
          lx_kw_cnt   = n + 1;
          lx_name_len = n + 1;
          if (lx_kw_cnt == w.len()) begin
            put_token(kw_kind[lx_kw], '0, 8'h00, 1'b1, ERR_NONE);
            lx_name_len = 0;
            lx_kw_cnt   = 0;
            lx_mode     = SCAN_IDLE;
          end
          return 1'b0;
        end
        // broken keyword prefix carries on as an identifier
        lx_kw_cnt = 0;
        lx_mode   = SCAN_IDENT;
        return 1'b1;
      end
      default: begin
        lx_mode = SCAN_IDLE;
        open_token(c);
        return 1'b0;
      end
    endcase
  endfunction

  // all tokens one accepted source byte causes, left in byte_tokens
  function automatic void tokenize_byte(logic [7:0] c, logic e);
    token_t t;
    byte_tokens.delete();
    for (int pass = 0; pass < 4; pass++)
      if (!lex_byte(c)) break;
    if (e) begin
      // source end flushes whatever is pending, marks the last token and starts over
      if (lx_mode == SCAN_NUMBER)
        flush_number();
      else if (lx_mode == SCAN_IDENT || lx_mode == SCAN_KEYWORD)
        flush_name();
      if (byte_tokens.size() > 0) begin
        t = byte_tokens.pop_back();
        t.stream_end = 1'b1;
        byte_tokens = {byte_tokens, t};
      end
      lex_reset();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random source text
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_name_start();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_mark();
    return marks[$urandom_range(0, 5)];
  endfunction

  function automatic void build_phrase(phrase_kind_e pk);
    string w;
    int    n;
    phrase_q.delete();
    w = "";
    case (pk)
      PH_KEYWORD: w = kw_word[$urandom_range(0, 2)];
      PH_BROKEN_KW: begin
        w = kw_word[$urandom_range(0, 2)];
        w = w.substr(0, $urandom_range(0, w.len() - 2));
      end
      PH_LIT_EDGE: begin
        case ($urandom_range(0, 3))
          0: w = "2147483647";
          1: w = "2147483648";
          2: w = "0";
          default: repeat ($urandom_range(10, 12)) phrase_q = {phrase_q, rand_digit()};
        endcase
      end
      default: w = "";
    endcase
    for (int i = 0; i < w.len(); i++)
      phrase_q = {phrase_q, w[i]};
    case (pk)
      PH_BROKEN_KW: begin
        // the prefix is cut by a word character, a mark or a blank
        case ($urandom_range(0, 2))
          0: phrase_q = {phrase_q, rand_word_char()};
          1: phrase_q = {phrase_q, rand_mark()};
          default: phrase_q = {phrase_q, 8'd32};
        endcase
      end
      PH_MARK: phrase_q = {phrase_q, rand_mark()};
      PH_LITERAL: repeat ($urandom_range(1, 9)) phrase_q = {phrase_q, rand_digit()};
      PH_NAME: begin
        phrase_q = {phrase_q, rand_name_start()};
        repeat ($urandom_range(0, 7)) phrase_q = {phrase_q, rand_word_char()};
      end
      PH_LONG_NAME: begin
        // lengths on both sides of the identifier limit
        phrase_q = {phrase_q, rand_name_start()};
        repeat ($urandom_range(NAME_MAX - 2, NAME_MAX + 1))
          phrase_q = {phrase_q, rand_word_char()};
      end
      PH_BAD_BYTE: begin
        case ($urandom_range(0, 3))
          0: phrase_q = {phrase_q, 8'($urandom_range(128, 255))};
          1: phrase_q = {phrase_q, bad_ascii[$urandom_range(0, bad_ascii.len() - 1)]};
          2: phrase_q = {phrase_q, 8'($urandom_range(0, 8))};
          default: phrase_q = {phrase_q, 8'($urandom_range(14, 31))};
        endcase
      end
      PH_SPACE: begin
        n = $urandom_range(9, 14);
        phrase_q = {phrase_q, (n == 14 ? 8'd32 : 8'(n))};
      end
      PH_NOISE: phrase_q = {phrase_q, 8'($urandom_range(0, 255))};
      default: ;
    endcase
    // words are mostly closed off, sometimes glued to what follows
    if (pk inside {PH_KEYWORD, PH_LITERAL, PH_LIT_EDGE, PH_NAME, PH_LONG_NAME} &&
        $urandom_range(0, 2) != 0)
      phrase_q = {phrase_q, ($urandom_range(0, 1) ? rand_mark() : 8'd32)};
  endfunction

  // ---------------------------------------------------------------------------
  // source side: one byte per handshake, random idle bursts in front of it
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c, input logic e, input bit typed,
                           input token_t tok);
    int gap;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.source_char <= c;
    in_if.source_end  <= e;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    // byte taken at this edge: bring the lexer copy up to date
    tokenize_byte(c, e);
    if (typed)
      pending_tokens = {pending_tokens, tok};
    else
      foreach (byte_tokens[i]) pending_tokens = {pending_tokens, byte_tokens[i]};
  endtask

  // stop offering bytes, then wait on clock edges until the block owes nothing
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  function automatic void add_row(logic [7:0] c, logic e);
    dir_row_t r;
    r.c     = c;
    r.e     = e;
    r.typed = 1'b0;
    r.tok   = '0;
    dir_rows = {dir_rows, r};
  endfunction

  // a row whose single token is written out by hand
  function automatic void add_typed(logic [7:0] c, logic e, logic [3:0] kind,
                                    logic [30:0] value, logic [7:0] ch, logic [1:0] err);
    dir_row_t r;
    r.c     = c;
    r.e     = e;
    r.typed = 1'b1;
    r.tok   = '{kind: kind, value: value, ch: ch, last: 1'b1, err: err, stream_end: e};
    dir_rows = {dir_rows, r};
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    phrase_kind_e forced [PHRASE_KINDS];
    phrase_kind_e pk;
    phrase_kind_e tmp;
    int           j;
    int           r;
    int           n_phr;
    int           sent;
    bit           ends;

    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.source_char = 8'h00;
    in_if.source_end  = 1'b0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    rx_hold_req       = 0;
    mismatch_count    = 0;
    lex_reset();

    // directed bytes: each mark straight after reset, a whole keyword, a literal ended by a
    // mark, keyword prefixes broken by a letter and by a mark, bad bytes at both ends of the
    // byte range, skipping after an error, and single-byte sources that end at once
    add_typed("(", 1'b0, KIND_LPAREN, '0, 8'h00, ERR_NONE);
    add_typed(")", 1'b0, KIND_RPAREN, '0, 8'h00, ERR_NONE);
    add_typed("{", 1'b0, KIND_LBRACE, '0, 8'h00, ERR_NONE);
    add_typed("}", 1'b0, KIND_RBRACE, '0, 8'h00, ERR_NONE);
    add_typed(";", 1'b0, KIND_SEMI,   '0, 8'h00, ERR_NONE);
    add_typed("=", 1'b0, KIND_ASSIGN, '0, 8'h00, ERR_NONE);
    add_row  ("t", 1'b0);
    add_row  ("o", 1'b0);
    add_typed("m", 1'b0, KIND_VOID,   '0, 8'h00, ERR_NONE);
    add_row  ("9", 1'b0);
    add_row  ("0", 1'b0);
    add_row  (")", 1'b0);
    add_row  ("t", 1'b0);
    add_row  ("e", 1'b0);
    add_row  (" ", 1'b0);
    add_row  ("r", 1'b0);
    add_row  ("e", 1'b0);
    add_row  (";", 1'b0);
    add_typed(8'hff, 1'b0, KIND_ERROR, '0, 8'h00, ERR_BAD_CHAR);
    add_row  ("a", 1'b0);
    add_row  (8'h7f, 1'b0);
    add_row  ("_", 1'b1);
    add_typed(8'h00, 1'b1, KIND_ERROR, '0, 8'h00, ERR_BAD_CHAR);
    add_typed("5",   1'b1, KIND_LIT,   31'd5, 8'h00, ERR_NONE);
    add_typed("_",   1'b1, KIND_IDENT, '0, "_", ERR_NONE);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      push_byte(dir_rows[i].c, dir_rows[i].e, dir_rows[i].typed, dir_rows[i].tok);

    // the first phrases visit every shape once, in random order
    for (int i = 0; i < PHRASE_KINDS; i++)
      forced[i] = phrase_kind_e'(i);
    for (int i = PHRASE_KINDS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = forced[i];
      forced[i] = forced[j];
      forced[j] = tmp;
    end

    n_phr = 0;
    sent  = 0;
    while (sent < RAND_ITEMS) begin
      if (n_phr == 4) begin
        // receiver holds off while a run of marks keeps coming, so the block backs up
        rx_hold_req = HOLD_CYCLES;
        push_byte(" ", 1'b1, 1'b0, '0);
        repeat (8) push_byte(rand_mark(), 1'b0, 1'b0, '0);
        sent += 9;
      end
      if (n_phr == PHRASE_KINDS)
        wait_drained();
      if (sent >= RAND_ITEMS - CALM_ITEMS) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end

      if (n_phr < PHRASE_KINDS) begin
        pk = forced[n_phr];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15)      pk = PH_KEYWORD;
        else if (r < 27) pk = PH_BROKEN_KW;
        else if (r < 42) pk = PH_MARK;
        else if (r < 57) pk = PH_LITERAL;
        else if (r < 62) pk = PH_LIT_EDGE;
        else if (r < 82) pk = PH_NAME;
        else if (r < 86) pk = PH_LONG_NAME;
        else if (r < 90) pk = PH_BAD_BYTE;
        else if (r < 95) pk = PH_SPACE;
        else             pk = PH_NOISE;
      end
      build_phrase(pk);

      // end the source more often while skipping, so errors do not waste the run
      ends = (lx_mode == SCAN_SKIP) ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 5) == 0);
      foreach (phrase_q[k])
        push_byte(phrase_q[k], ends && (k == phrase_q.size() - 1), 1'b0, '0);
      sent += phrase_q.size();
      n_phr++;
    end

    // close the source so anything still pending comes out
    push_byte(";", 1'b1, 1'b0, '0);
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: ready drops in random bursts, plus one long requested hold
  initial begin : result_sink
    int stall_left;
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req - 1;
        rx_hold_req = 0;
        out_if.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // every accepted token item against the oldest one owed
  always @(posedge clk) begin : token_check
    token_t got;
    token_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.kind       = out_if.token_kind;
      got.value      = out_if.literal_value;
      got.ch         = out_if.text_char;
      got.last       = out_if.text_last;
      got.err        = out_if.error_code;
      got.stream_end = out_if.stream_end;
      if (pending_tokens.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected token: expected none, got kind %0d value %0d char %h",
                 $time, got.kind, got.value, got.ch);
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.ch !== want.ch ||
            got.last !== want.last || got.err !== want.err ||
            got.stream_end !== want.stream_end) begin
          mismatch_count++;
          $display("%0t: token mismatch: expected kind %0d value %0d char %h last %b err %0d end %b",
                   $time, want.kind, want.value, want.ch, want.last, want.err,
                   want.stream_end);
          $display("%0t:   got kind %0d value %0d char %h last %b err %0d end %b",
                   $time, got.kind, got.value, got.ch, got.last, got.err, got.stream_end);
        end
      end
    end
  end

  // watchdog: too long with no handshake on either channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d tokens still owed",
               $time, quiet, pending_tokens.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

### files.f
hdl/kwl_pkg.sv
hdl/kwl_if.sv
hdl/kwl_id_store.sv
hdl/kwl_scan.sv
hdl/keyword_token_lexer_unit.sv
sim/testbench.sv
